// File: hdl/phm_pkg.sv
// ----------------------------------------------------------------------------
// phm_pkg
// Shared types, constants and helpers of the peak-hold level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package phm_pkg;

    // parameter defaults
    localparam int CHANNEL_SLOTS_DEFAULT     = 8;
    localparam int LOG_TABLE_ENTRIES_DEFAULT = 64;

    // register map
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_FLOOR_RANGE   = 2'd1;
    localparam logic [1:0] CFG_FALLOFF_RATE  = 2'd2;
    localparam logic [1:0] CFG_PEAK_HOLD_MS  = 2'd3;

    // register reset values
    localparam logic [3:0]  CHANNEL_COUNT_RESET = 4'd2;
    localparam logic [6:0]  FLOOR_RANGE_RESET   = 7'd96;
    localparam logic [11:0] FALLOFF_RATE_RESET  = 12'd82;
    localparam logic [15:0] PEAK_HOLD_MS_RESET  = 16'd1600;

    // level and peak after reset: minus the reset floor, in 1/4096 dB
    localparam logic signed [19:0] METER_FLOOR_RESET = -20'sd393216;

    // 6.0206 dB per octave in 1/4096 dB, and log2 of full scale
    localparam logic [14:0] DB_PER_OCTAVE = 15'd24660;
    localparam logic [4:0]  FULL_SCALE_LOG2 = 5'd23;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        OP_SAMPLE,
        OP_TICK
    } op_t;

    // classified item handed from the front to the back
    typedef struct packed {
        op_t         op;
        logic        hit;        // sample channel is in use
        logic [2:0]  channel;
        logic [22:0] mag;        // saturated magnitude
        logic        eob;
        logic [9:0]  elapsed;
    } phm_cmd_t;

    typedef struct packed {
        logic [3:0]  channel_count;
        logic [6:0]  floor_range;
        logic [11:0] falloff_rate;
        logic [15:0] peak_hold_ms;
    } phm_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CV_LOAD,
        ST_CV_INDEX,
        ST_CV_ROM,
        ST_CV_SCALE,
        ST_CV_UPDATE,
        ST_TICK
    } phm_state_t;

    // channels in use
    function automatic logic [5:0] active_count(input logic [3:0] cc, input int max_ch);
        return (int'(cc) < max_ch) ? 6'(cc) : 6'(max_ch);
    endfunction

endpackage

`default_nettype wire

// File: hdl/phm_if.sv
// ----------------------------------------------------------------------------
// phm_if
// Valid/ready channels of the meter: input items and meter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface phm_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [2:0]         channel;
    logic signed [23:0] sample;
    logic               end_of_block;
    logic [9:0]         elapsed_ms;

    modport source (output valid, action, channel, sample, end_of_block, elapsed_ms,
                    input ready);
    modport sink   (input valid, action, channel, sample, end_of_block, elapsed_ms,
                    output ready);
endinterface

interface phm_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         out_channel;
    logic signed [19:0] level_db;
    logic signed [19:0] peak_db;
    logic               last;

    modport source (output valid, out_channel, level_db, peak_db, last, input ready);
    modport sink   (input valid, out_channel, level_db, peak_db, last, output ready);
endinterface

`default_nettype wire

// File: hdl/peak_hold_level_meter.sv
// ----------------------------------------------------------------------------
// peak_hold_level_meter
// Multichannel peak program meter with peak hold: configuration registers,
// classifying front end, command queue and channel back end.
// ----------------------------------------------------------------------------
// Items enter through a two-entry command queue, so the input stays ready
// while the back end works, until the queue is full. The back end runs one
// command at a time: a sample with end_of_block runs five steps for each
// channel in use (leading-one search, table index, log table read, dB
// scaling, update), and a tick makes one reading per channel in use, each
// result moving into the output register as soon as the previous one has
// been taken. Levels and peaks are in 1/4096 dB below full scale. Registers
// must be written only while the meter is idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_hold_level_meter
    import phm_pkg::*;
#(
    parameter int CHANNEL_SLOTS     = CHANNEL_SLOTS_DEFAULT,
    parameter int LOG_TABLE_ENTRIES = LOG_TABLE_ENTRIES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    phm_in_if.sink           samples,
    phm_out_if.source        meter
);

    phm_cfg_t cfg_reg;
    logic     f_valid, f_ready, q_valid, q_ready;
    phm_cmd_t f_cmd, q_cmd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count <= CHANNEL_COUNT_RESET;
            cfg_reg.floor_range   <= FLOOR_RANGE_RESET;
            cfg_reg.falloff_rate  <= FALLOFF_RATE_RESET;
            cfg_reg.peak_hold_ms  <= PEAK_HOLD_MS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[3:0];
                CFG_FLOOR_RANGE:   cfg_reg.floor_range   <= cfg_data[6:0];
                CFG_FALLOFF_RATE:  cfg_reg.falloff_rate  <= cfg_data[11:0];
                CFG_PEAK_HOLD_MS:  cfg_reg.peak_hold_ms  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    phm_front #(
        .CHANNEL_SLOTS (CHANNEL_SLOTS)
    ) u_front (
        .channel_count (cfg_reg.channel_count),
        .samples       (samples),
        .cmd_valid     (f_valid),
        .cmd           (f_cmd),
        .cmd_ready     (f_ready)
    );

    phm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_cmd   (f_cmd),
        .wr_ready (f_ready),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd),
        .rd_ready (q_ready)
    );

    phm_back #(
        .CHANNEL_SLOTS     (CHANNEL_SLOTS),
        .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_ready (q_ready),
        .meter     (meter)
    );

endmodule

`default_nettype wire

// File: hdl/phm_front.sv
// ----------------------------------------------------------------------------
// phm_front
// Accepts input beats and classifies them into queue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module phm_front
    import phm_pkg::*;
#(
    parameter int CHANNEL_SLOTS = CHANNEL_SLOTS_DEFAULT
) (
    input  wire logic [3:0] channel_count,
    phm_in_if.sink          samples,
    output logic            cmd_valid,
    output phm_cmd_t        cmd,
    input  wire logic       cmd_ready
);

    logic [23:0] mag_full;
    logic [5:0]  n_act;

    // magnitude, saturated to 23 bits
    assign mag_full = samples.sample[23] ? (~samples.sample + 24'd1) : samples.sample;
    assign n_act    = active_count(channel_count, CHANNEL_SLOTS);

    always_comb
    begin
        cmd.op      = samples.action ? OP_TICK : OP_SAMPLE;
        cmd.hit     = (6'(samples.channel) < n_act);
        cmd.channel = samples.channel;
        cmd.mag     = mag_full[23] ? 23'h7FFFFF : mag_full[22:0];
        cmd.eob     = samples.end_of_block;
        cmd.elapsed = samples.elapsed_ms;
    end

    assign cmd_valid     = samples.valid;
    assign samples.ready = cmd_ready;

endmodule

`default_nettype wire

// File: hdl/phm_queue.sv
// ----------------------------------------------------------------------------
// phm_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module phm_queue
    import phm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_valid,
    input  wire phm_cmd_t wr_cmd,
    output logic          wr_ready,
    output logic          rd_valid,
    output phm_cmd_t      rd_cmd,
    input  wire logic     rd_ready
);

    phm_cmd_t          store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push, pop;

    assign wr_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = store_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointers wrap at the power-of-two depth
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hdl/phm_back.sv
// ----------------------------------------------------------------------------
// phm_back
// Channel state, block-end dB conversion sequencer and tick decay with
// result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module phm_back
    import phm_pkg::*;
#(
    parameter int CHANNEL_SLOTS     = CHANNEL_SLOTS_DEFAULT,
    parameter int LOG_TABLE_ENTRIES = LOG_TABLE_ENTRIES_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire phm_cfg_t cfg,
    input  wire logic     cmd_valid,
    input  wire phm_cmd_t cmd,
    output logic          cmd_ready,
    phm_out_if.source     meter
);

    localparam int CH_W   = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
    localparam int IDX_W  = $clog2(LOG_TABLE_ENTRIES);
    localparam int NW     = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int PROD_W = 22 + NW;

    typedef logic [15:0] rom_t [LOG_TABLE_ENTRIES];

    // log2(1 + idx/N) in Q16, by repeated squaring
    function automatic logic [15:0] mant_log2(input int idx);
        logic [63:0] x;
        logic [15:0] r;
        x = ((64'(LOG_TABLE_ENTRIES) + 64'(idx)) << 30) / LOG_TABLE_ENTRIES;
        r = '0;
        for (int k = 0; k < 16; k++)
        begin
            x = (x * x) >> 30;
            r = {r[14:0], 1'b0};
            if (x >= (64'd2 << 30))
            begin
                r[0] = 1'b1;
                x    = x >> 1;
            end
        end
        return r;
    endfunction

    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i < LOG_TABLE_ENTRIES; i++)
        begin
            t[i] = mant_log2(i);
        end
        return t;
    endfunction

    localparam rom_t LOG_ROM = build_rom();

    // channel state
    logic [22:0]        rpeak_reg [CHANNEL_SLOTS];
    logic signed [19:0] level_reg [CHANNEL_SLOTS];
    logic signed [19:0] held_reg  [CHANNEL_SLOTS];
    logic [15:0]        hold_reg  [CHANNEL_SLOTS];

    phm_state_t         state_reg, state_next;
    logic [CH_W-1:0]    cnt_reg, cnt_next;
    logic               out_valid_reg;

    // conversion datapath
    logic [4:0]         e_reg;
    logic [21:0]        frac_reg;
    logic               zero_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [15:0]        rom_q_reg;
    logic [19:0]        mag_reg;
    logic [21:0]        decay_reg;
    logic [9:0]         el_reg;

    // output payload
    logic [2:0]         out_ch_reg;
    logic signed [19:0] out_level_reg;
    logic signed [19:0] out_peak_reg;
    logic               out_last_reg;

    logic [5:0]         n_act;
    logic               last_ch;
    logic [CH_W-1:0]    rd_idx;
    logic [7:0]         ch_ext;
    logic [22:0]        peak_cur;
    logic signed [19:0] level_cur, held_cur;
    logic [15:0]        hold_cur;
    logic               pop_fire, tick_fire, upd_fire, clear_all;

    assign n_act   = active_count(cfg.channel_count, CHANNEL_SLOTS);
    assign last_ch = ((6'(cnt_reg) + 6'd1) == n_act);
    assign ch_ext  = 8'(cmd.channel);
    assign rd_idx  = (state_reg == ST_IDLE) ? ch_ext[CH_W-1:0] : cnt_reg;

    assign peak_cur  = rpeak_reg[rd_idx];
    assign level_cur = level_reg[rd_idx];
    assign held_cur  = held_reg[rd_idx];
    assign hold_cur  = hold_reg[rd_idx];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_ready  = 1'b0;
        tick_fire  = 1'b0;
        upd_fire   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid && n_act != 6'd0)
                begin
                    if (cmd.op == OP_TICK)
                    begin
                        state_next = ST_TICK;
                        cnt_next   = '0;
                    end
                    else if (cmd.eob)
                    begin
                        state_next = ST_CV_LOAD;
                        cnt_next   = '0;
                    end
                end
            end
            ST_CV_LOAD:   state_next = ST_CV_INDEX;
            ST_CV_INDEX:  state_next = ST_CV_ROM;
            ST_CV_ROM:    state_next = ST_CV_SCALE;
            ST_CV_SCALE:  state_next = ST_CV_UPDATE;
            ST_CV_UPDATE:
            begin
                upd_fire = 1'b1;
                if (last_ch)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_CV_LOAD;
                end
            end
            ST_TICK:
            begin
                if (!out_valid_reg || meter.ready)
                begin
                    tick_fire = 1'b1;
                    if (last_ch)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign pop_fire = cmd_ready && cmd_valid;

    // leading one of the running peak
    logic [4:0]  lead;
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 23; i++)
        begin
            if (peak_cur[i])
            begin
                lead = 5'(i);
            end
        end
    end

    // table index, log2 below full scale and scaling to dB
    logic [PROD_W-1:0] idx_prod, idx_shift;
    logic [20:0]       dlog;
    logic [35:0]       mag_prod;
    assign idx_prod  = PROD_W'(frac_reg) * PROD_W'(LOG_TABLE_ENTRIES);
    assign idx_shift = idx_prod >> e_reg;
    assign dlog      = {FULL_SCALE_LOG2, 16'd0} - {e_reg, 16'd0} - 21'(rom_q_reg);
    assign mag_prod  = 36'(dlog) * 36'(DB_PER_OCTAVE) + 36'd32768;

    // clamp to the floor
    logic [18:0]        lim;
    logic [19:0]        mag_c;
    logic signed [19:0] db_new;
    assign lim    = {cfg.floor_range, 12'd0};
    assign mag_c  = (zero_reg || mag_reg > 20'(lim)) ? 20'(lim) : mag_reg;
    assign db_new = -$signed(mag_c);

    // tick: decay, clamp, hold count and release
    logic signed [24:0] lv_wide, floor_w;
    logic signed [19:0] level_new;
    logic [16:0]        h_sum;
    logic [15:0]        h_sat;
    logic               release_pk;
    always_comb
    begin
        floor_w = -$signed({6'd0, lim});
        lv_wide = 25'(level_cur) - $signed({3'd0, decay_reg});
        if (lv_wide < floor_w)
        begin
            lv_wide = floor_w;
        end
        if (lv_wide > 25'sd0)
        begin
            lv_wide = 25'sd0;
        end
        level_new  = lv_wide[19:0];
        h_sum      = {1'b0, hold_cur} + 17'(el_reg);
        h_sat      = h_sum[16] ? 16'hFFFF : h_sum[15:0];
        release_pk = (level_new > held_cur) || (h_sat > cfg.peak_hold_ms);
    end

    assign clear_all = (pop_fire && cmd.op == OP_SAMPLE && cmd.eob && n_act == 6'd0)
                     || (upd_fire && last_ch);

    // channel state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNEL_SLOTS; i++)
            begin
                rpeak_reg[i] <= '0;
                level_reg[i] <= METER_FLOOR_RESET;
                held_reg[i]  <= METER_FLOOR_RESET;
                hold_reg[i]  <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_fire && cmd.op == OP_SAMPLE && cmd.hit && cmd.mag > peak_cur)
            begin
                rpeak_reg[rd_idx] <= cmd.mag;
            end
            if (upd_fire)
            begin
                if (db_new > level_cur)
                begin
                    level_reg[rd_idx] <= db_new;
                end
                if (db_new > held_cur)
                begin
                    held_reg[rd_idx] <= db_new;
                    hold_reg[rd_idx] <= '0;
                end
            end
            if (clear_all)
            begin
                for (int i = 0; i < CHANNEL_SLOTS; i++)
                begin
                    rpeak_reg[i] <= '0;
                end
            end
            if (tick_fire)
            begin
                level_reg[rd_idx] <= level_new;
                held_reg[rd_idx]  <= release_pk ? level_new : held_cur;
                hold_reg[rd_idx]  <= release_pk ? 16'd0 : h_sat;
            end
            if (tick_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (meter.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath and payload registers
    always_ff @(posedge clk)
    begin
        if (pop_fire && cmd.op == OP_TICK)
        begin
            decay_reg <= 22'(cmd.elapsed) * 22'(cfg.falloff_rate);
            el_reg    <= cmd.elapsed;
        end
        if (state_reg == ST_CV_LOAD)
        begin
            e_reg    <= lead;
            frac_reg <= 22'(peak_cur ^ (23'd1 << lead));
            zero_reg <= (peak_cur == '0);
        end
        if (state_reg == ST_CV_INDEX)
        begin
            idx_reg <= idx_shift[IDX_W-1:0];
        end
        rom_q_reg <= LOG_ROM[idx_reg];
        if (state_reg == ST_CV_SCALE)
        begin
            mag_reg <= mag_prod[35:16];
        end
        if (tick_fire)
        begin
            out_ch_reg    <= 3'(cnt_reg);
            out_level_reg <= level_new;
            out_peak_reg  <= release_pk ? level_new : held_cur;
            out_last_reg  <= last_ch;
        end
    end

    assign meter.valid       = out_valid_reg;
    assign meter.out_channel = out_ch_reg;
    assign meter.level_db    = out_level_reg;
    assign meter.peak_db     = out_peak_reg;
    assign meter.last        = out_last_reg;

endmodule

`default_nettype wire

// File: bench/tb_peak_hold_level_meter.sv
// ----------------------------------------------------------------------------
// tb_peak_hold_level_meter
// Self-checking bench for the peak-hold level meter. A cycle-free model of
// the meter follows every accepted beat and queues the readings each tick
// should produce. Readings from the block are compared in order. Directed
// tests cover reset, sample extremes, channel count, floor changes, hold
// saturation and back-pressure. Random frames of samples and ticks follow, with
// random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_peak_hold_level_meter;
    timeunit 1ns;
    timeprecision 1ps;

    import phm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int LIMIT_CYCLES  = 1_000_000;
    // two queued commands plus one in flight
    localparam int SETTLE_CYCLES = 150;
    localparam int LONG_HOLD_OFF = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int NCH           = CHANNEL_SLOTS_DEFAULT;
    localparam int MAG_MAX       = 'h7FFFFF;
    localparam int HOLD_SAT      = 65535;

    typedef longint unsigned u64_t;

    typedef struct {
        op_t                op;
        logic [2:0]         channel;
        logic signed [23:0] sample;
        logic               eob;
        logic [9:0]         elapsed;
    } meter_item_t;

    typedef struct {
        logic [2:0]         channel;
        logic signed [19:0] level_db;
        logic signed [19:0] peak_db;
        logic               last;
    } meter_reading_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    phm_in_if  samples_if ();
    phm_out_if meter_if ();

    // model configuration
    logic [3:0]  cfg_channels;
    logic [6:0]  cfg_range_db;
    logic [11:0] cfg_falloff;
    logic [15:0] cfg_hold_ms;

    // model state
    logic [22:0] peak_run [NCH];
    int          level_now [NCH];
    int          peak_held [NCH];
    int          hold_ms_count [NCH];

    meter_reading_t pending_readings [$];

    int error_count     = 0;
    int cycle_count     = 0;
    int hold_off_cycles = 0;
    bit steady_flow     = 1'b0;

    peak_hold_level_meter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_if),
        .meter     (meter_if)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Meter model
    // ------------------------------------------------------------------------

    function automatic int channels_in_use();
        return (int'(cfg_channels) < NCH) ? int'(cfg_channels) : NCH;
    endfunction

    // log2(1 + idx/N) in Q16, bit by bit through repeated squaring
    function automatic u64_t log2_fraction(input int idx);
        u64_t x;
        u64_t bits;
        x = (u64_t'(LOG_TABLE_ENTRIES_DEFAULT + idx) << 30) / LOG_TABLE_ENTRIES_DEFAULT;
        bits = 0;
        for (int k = 0; k < 16; k++)
        begin
            x = (x * x) >> 30;
            bits = bits << 1;
            if (x >= (u64_t'(1) << 31))
            begin
                bits = bits | 1;
                x = x >> 1;
            end
        end
        return bits;
    endfunction

    // running peak to dB below full scale, clamped at the floor
    function automatic int peak_in_db(input logic [22:0] p);
        longint lim;
        longint e;
        longint idx;
        longint d;
        longint mag;
        lim = longint'(cfg_range_db) * 4096;
        if (p == 0)
            return -int'(lim);
        e = 0;
        while (e < 22 && (p >> (e + 1)) != 0)
            e++;
        idx = ((longint'(p) - (longint'(1) << e)) * LOG_TABLE_ENTRIES_DEFAULT) >> e;
        d = (longint'(FULL_SCALE_LOG2) << 16)
            - ((e << 16) + longint'(log2_fraction(int'(idx))));
        mag = (d * longint'(DB_PER_OCTAVE) + 32768) >> 16;
        if (mag > lim)
            mag = lim;
        return -int'(mag);
    endfunction

    function automatic void reset_meter_model();
        cfg_channels = CHANNEL_COUNT_RESET;
        cfg_range_db = FLOOR_RANGE_RESET;
        cfg_falloff  = FALLOFF_RATE_RESET;
        cfg_hold_ms  = PEAK_HOLD_MS_RESET;
        for (int i = 0; i < NCH; i++)
        begin
            peak_run[i]      = '0;
            level_now[i]     = -int'(cfg_range_db) * 4096;
            peak_held[i]     = -int'(cfg_range_db) * 4096;
            hold_ms_count[i] = 0;
        end
    endfunction

    // advance the model by one accepted beat, queue the readings it causes
    function automatic void apply_item(input meter_item_t it);
        int n;
        int mag;
        int db;
        int decay;
        int lv;
        int floor_v;
        meter_reading_t r;
        n = channels_in_use();
        if (it.op == OP_SAMPLE)
        begin
            mag = (it.sample < 0) ? -int'(it.sample) : int'(it.sample);
            if (mag > MAG_MAX)
                mag = MAG_MAX;
            if (int'(it.channel) < n && mag > int'(peak_run[it.channel]))
                peak_run[it.channel] = mag[22:0];
            if (it.eob)
            begin
                for (int i = 0; i < n; i++)
                begin
                    db = peak_in_db(peak_run[i]);
                    if (db > level_now[i])
                        level_now[i] = db;
                    if (db > peak_held[i])
                    begin
                        peak_held[i] = db;
                        hold_ms_count[i] = 0;
                    end
                end
                for (int i = 0; i < NCH; i++)
                    peak_run[i] = '0;
            end
        end
        else
        begin
            decay = int'(it.elapsed) * int'(cfg_falloff);
            floor_v = -int'(cfg_range_db) * 4096;
            for (int i = 0; i < n; i++)
            begin
                lv = level_now[i] - decay;
                if (lv < floor_v)
                    lv = floor_v;
                if (lv > 0)
                    lv = 0;
                level_now[i] = lv;
                hold_ms_count[i] = hold_ms_count[i] + int'(it.elapsed);
                if (hold_ms_count[i] > HOLD_SAT)
                    hold_ms_count[i] = HOLD_SAT;
                if (lv > peak_held[i] || hold_ms_count[i] > int'(cfg_hold_ms))
                begin
                    peak_held[i] = lv;
                    hold_ms_count[i] = 0;
                end
                r.channel  = 3'(i);
                r.level_db = 20'(lv);
                r.peak_db  = 20'(peak_held[i]);
                r.last     = (i == n - 1);
                pending_readings.push_back(r);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic meter_item_t make_sample(input logic [2:0] ch,
                                                input logic signed [23:0] s,
                                                input logic eob);
        meter_item_t it;
        it.op      = OP_SAMPLE;
        it.channel = ch;
        it.sample  = s;
        it.eob     = eob;
        it.elapsed = 10'($urandom);  // ignored on samples
        return it;
    endfunction

    function automatic meter_item_t make_tick(input logic [9:0] el);
        meter_item_t it;
        it.op      = OP_TICK;
        it.channel = 3'($urandom);   // ignored on ticks
        it.sample  = 24'($urandom);
        it.eob     = 1'($urandom);
        it.elapsed = el;
        return it;
    endfunction

    // magnitudes spread over the whole dB scale, plus raw and extreme codes
    function automatic logic signed [23:0] random_sample();
        logic [22:0] m;
        case ($urandom_range(9))
            0: return 24'($urandom);
            1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            default:
            begin
                m = 23'($urandom) >> $urandom_range(22);
                return $urandom_range(1) ? -$signed({1'b0, m}) : $signed({1'b0, m});
            end
        endcase
    endfunction

    function automatic logic [9:0] random_elapsed();
        return ($urandom_range(9) == 0) ? 10'($urandom_range(1000)) : 10'($urandom_range(40));
    endfunction

    function automatic logic [2:0] pick_channel(input int n);
        if (n == 0 || $urandom_range(7) == 0)
            return 3'($urandom);
        return 3'($urandom_range(n - 1));
    endfunction

    function automatic void report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // offer one beat, hold it until accepted, then update the model
    task automatic send_item(input meter_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid        <= 1'b1;
        samples_if.action       <= it.op;
        samples_if.channel      <= it.channel;
        samples_if.sample       <= it.sample;
        samples_if.end_of_block <= it.eob;
        samples_if.elapsed_ms   <= it.elapsed;
        do
            @(posedge clk);
        while (!samples_if.ready);
        apply_item(it);
    endtask

    // stop sending, wait for every reading, then let the back end settle
    task automatic wait_idle();
        samples_if.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write enable stays high across back-to-back writes
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // unused upper data bits carry noise, the register keeps its own width
    task automatic program_meter(input logic [3:0] cc, input logic [6:0] db,
                                 input logic [11:0] fall, input logic [15:0] hold);
        write_reg(CFG_CHANNEL_COUNT, {12'($urandom), cc});
        write_reg(CFG_FLOOR_RANGE, {9'($urandom), db});
        write_reg(CFG_FALLOFF_RATE, {4'($urandom), fall});
        write_reg(CFG_PEAK_HOLD_MS, hold);
        cfg_we <= 1'b0;
        cfg_channels = cc;
        cfg_range_db = db;
        cfg_falloff  = fall;
        cfg_hold_ms  = hold;
    endtask

    // frames of samples, mostly closed by end_of_block, then one or two ticks
    task automatic run_frames(input int item_goal);
        int sent;
        int n;
        int k;
        logic eob;
        sent = 0;
        while (sent < item_goal)
        begin
            steady_flow = ($urandom_range(3) == 0);
            n = channels_in_use();
            k = $urandom_range(3 * n + 1, 1);
            for (int s = 0; s < k; s++)
            begin
                eob = (s == k - 1) ? ($urandom_range(9) != 0) : ($urandom_range(11) == 0);
                send_item(make_sample(pick_channel(n), random_sample(), eob));
            end
            sent += k;
            k = $urandom_range(2, 1);
            for (int t = 0; t < k; t++)
                send_item(make_tick(random_elapsed()));
            sent += k;
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // a zero-length tick reports the reset floor on the default two channels
    task automatic test_reset_state();
        send_item(make_tick(10'd0));
        wait_idle();
    endtask

    // full scale, saturating negative code, ignored channel still commits
    task automatic test_sample_extremes();
        send_item(make_sample(3'd0, 24'sh7FFFFF, 1'b0));
        send_item(make_sample(3'd1, 24'sh800000, 1'b0));
        send_item(make_sample(3'd7, -24'sd1, 1'b1));
        send_item(make_tick(10'd0));
        send_item(make_sample(3'd0, 24'sh400000, 1'b0));
        send_item(make_sample(3'd1, -24'sh2AAAAA, 1'b1));
        send_item(make_tick(10'd1000));
        send_item(make_sample(3'd0, 24'sd1, 1'b0));
        send_item(make_sample(3'd1, 24'sd0, 1'b1));
        send_item(make_tick(10'd1000));
        send_item(make_tick(10'd1));
        wait_idle();
    endtask

    // zero channels: commits do nothing, ticks give no readings; then above max
    task automatic test_channel_count();
        program_meter(4'd0, 7'd96, 12'd82, 16'd1600);
        send_item(make_sample(3'd0, 24'sh7FFFFF, 1'b1));
        send_item(make_tick(10'd500));
        wait_idle();
        program_meter(4'd15, 7'd96, 12'd82, 16'd1600);
        send_item(make_sample(3'd5, -24'sh123456, 1'b0));
        send_item(make_sample(3'd7, 24'sh000FFF, 1'b1));
        send_item(make_tick(10'd3));
        wait_idle();
    endtask

    // floor moves up, down to the deepest code, and to zero dB
    task automatic test_floor_change();
        program_meter(4'd2, 7'd30, 12'd0, 16'd1600);
        send_item(make_tick(10'd0));
        wait_idle();
        program_meter(4'd2, 7'd127, 12'd4095, 16'd0);
        send_item(make_tick(10'd1000));
        wait_idle();
        program_meter(4'd2, 7'd0, 12'd4095, 16'd0);
        send_item(make_sample(3'd0, 24'sd5, 1'b1));
        send_item(make_tick(10'd7));
        wait_idle();
    endtask

    // hold counter stops at its maximum, so the longest hold never expires
    task automatic test_hold_saturation();
        program_meter(4'd1, 7'd120, 12'd1, 16'd65535);
        send_item(make_sample(3'd0, 24'sh7FFFFF, 1'b1));
        for (int t = 0; t < 70; t++)
            send_item(make_tick(10'($urandom_range(1000, 950))));
        wait_idle();
        program_meter(4'd1, 7'd120, 12'd1, 16'd65534);
        send_item(make_tick(10'd0));
        wait_idle();
    endtask

    // reading sink held off for a long stretch while beats keep coming
    task automatic test_back_pressure();
        program_meter(4'd8, 7'd120, 12'd2000, 16'd300);
        steady_flow = 1'b1;
        hold_off_cycles = LONG_HOLD_OFF;
        for (int f = 0; f < 2; f++)
        begin
            for (int c = 0; c < NCH; c++)
                send_item(make_sample(3'(c), random_sample(), c == NCH - 1));
            send_item(make_tick(random_elapsed()));
            send_item(make_tick(random_elapsed()));
        end
        steady_flow = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        program_meter(4'd8, 7'd120, 12'd4095, 16'd0);
        run_frames(10);
        wait_idle();
        program_meter(4'd1, 7'd30, 12'd0, 16'd65535);
        run_frames(10);
        wait_idle();
        repeat (2)
        begin
            program_meter(4'($urandom_range(8, 1)), 7'($urandom_range(120, 30)),
                          12'($urandom), 16'($urandom_range(3000)));
            run_frames(10);
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Reading sink: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        stall = 0;
        meter_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                meter_if.ready <= 1'b0;
                hold_off_cycles--;
            end
            else if (stall > 0)
            begin
                meter_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                stall = (!steady_flow && $urandom_range(3) == 0) ? pick_gap() : 0;
                meter_if.ready <= (stall == 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Reading checker: each accepted beat against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        meter_reading_t want;
        if (rst_n && meter_if.valid && meter_if.ready)
        begin
            if (pending_readings.size() == 0)
                report_error($sformatf("unexpected reading ch %0d level %0d peak %0d last %0b",
                                       meter_if.out_channel, meter_if.level_db,
                                       meter_if.peak_db, meter_if.last));
            else
            begin
                want = pending_readings.pop_front();
                if (meter_if.out_channel !== want.channel || meter_if.level_db !== want.level_db
                    || meter_if.peak_db !== want.peak_db || meter_if.last !== want.last)
                    report_error($sformatf({"reading ch/level/peak/last expected %0d %0d %0d %0b",
                                            " got %0d %0d %0d %0b"},
                                           want.channel, want.level_db, want.peak_db, want.last,
                                           meter_if.out_channel, meter_if.level_db,
                                           meter_if.peak_db, meter_if.last));
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_peak_hold_level_meter: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= CFG_CHANNEL_COUNT;
        cfg_data                <= '0;
        samples_if.valid        <= 1'b0;
        samples_if.action       <= OP_SAMPLE;
        samples_if.channel      <= '0;
        samples_if.sample       <= '0;
        samples_if.end_of_block <= 1'b0;
        samples_if.elapsed_ms   <= '0;
        reset_meter_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_sample_extremes();
        test_channel_count();
        test_floor_change();
        test_hold_saturation();
        test_back_pressure();
        test_random_traffic();

        wait_idle();
        if (error_count == 0 && pending_readings.size() == 0)
            $display("tb_peak_hold_level_meter: done, clean");
        else
            $display("tb_peak_hold_level_meter: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
